>>> design/bba_pkg.sv
// package for the bitmap block allocator: field widths, codes and the
// command, status and response types shared by controller, datapath and top
// no dependencies
package bba_pkg;

    localparam int CMD_W          = 3;
    localparam int ID_W           = 12;
    localparam int ST_W           = 2;
    localparam int REG_W          = 13;
    localparam int CFG_IDX_W      = 2;
    localparam int MAP_WORD_W     = 64;
    localparam int MAP_WORD_SHIFT = 6;

    localparam logic [REG_W-1:0] BLOCK_COUNT_RST = 13'd4096;

    typedef enum logic [CMD_W-1:0] {
        CMD_ALLOC_DATA = 3'd0,
        CMD_ALLOC_RSV  = 3'd1,
        CMD_MARK_USED  = 3'd2,
        CMD_MARK_FREE  = 3'd3,
        CMD_QUERY      = 3'd4,
        CMD_SET_PTR    = 3'd5
    } t_cmd;

    typedef enum logic [ST_W-1:0] {
        ST_OK      = 2'd0,
        ST_NOSPACE = 2'd1,
        ST_INVALID = 2'd2
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BLOCK_COUNT = 2'd0,
        REG_FIRST_DATA  = 2'd1,
        REG_FIRST_RSV   = 2'd2
    } t_reg_idx;

    typedef enum logic [1:0] {
        SC_PTR  = 2'd0,
        SC_WRAP = 2'd1,
        SC_RSV  = 2'd2
    } t_scan_sel;

    typedef struct packed {
        logic      clear;
        logic      load_id;
        logic      scan_start;
        t_scan_sel scan_sel;
        logic      id_rd;
        logic      take;
        logic      take_sp;
        logic      id_take;
        logic      id_give;
        logic      set_sp;
    } t_dp_cmd;

    typedef struct packed {
        logic             clr_last;
        logic             fc_zero;
        logic             sp_lt_lim;
        logic             fdb_lt_lim;
        logic             frb_lt_fdb;
        logic             id_bad;
        logic             id_bit;
        logic             scan_hit;
        logic             scan_miss;
        logic [ID_W-1:0]  hit_blk;
        logic [REG_W-1:0] free_total;
        logic [REG_W-1:0] free_data_total;
    } t_dp_sts;

    typedef struct packed {
        logic [ST_W-1:0]  status;
        logic [ID_W-1:0]  allocated_block;
        logic             is_free;
        logic [REG_W-1:0] free_total;
        logic [REG_W-1:0] free_data_total;
    } t_rsp;

endpackage

>>> design/bba_ifs.sv
// channel interfaces of the bitmap block allocator: command, response and
// configuration write, each with valid/ready; depends on bba_pkg
interface bba_cmd_if;
    import bba_pkg::*;
    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  command;
    logic [ID_W-1:0]   target_blk;
    modport source (output valid, output command, output target_blk, input ready);
    modport sink   (input valid, input command, input target_blk, output ready);
endinterface

interface bba_rsp_if;
    import bba_pkg::*;
    logic              valid;
    logic              ready;
    logic [ST_W-1:0]   status;
    logic [ID_W-1:0]   allocated_block;
    logic              is_free;
    logic [REG_W-1:0]  free_total;
    logic [REG_W-1:0]  free_data_total;
    modport source (output valid, output status, output allocated_block, output is_free,
                    output free_total, output free_data_total, input ready);
    modport sink   (input valid, input status, input allocated_block, input is_free,
                    input free_total, input free_data_total, output ready);
endinterface

interface bba_cfg_if;
    import bba_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [REG_W-1:0]      data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

>>> design/bba_ram.sv
// generic simple dual-port ram: one write port, one read port with
// registered read data held while read enable is low; no dependencies
module bba_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic                                   i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> design/bba_dp.sv
// datapath of the bitmap block allocator: free map ram, word scanner, free
// counters, search pointer and configuration registers; depends on bba_pkg, bba_ram
module bba_dp #(
    parameter int NUM_BLOCKS = 4096
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [bba_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [bba_pkg::REG_W-1:0]      i_cfg_data,
    input  logic [bba_pkg::ID_W-1:0]       i_target_blk,
    input  bba_pkg::t_dp_cmd               i_cmd,
    output bba_pkg::t_dp_sts               o_sts
);
    import bba_pkg::*;

    localparam int W     = MAP_WORD_W;
    localparam int WB    = MAP_WORD_SHIFT;
    localparam int DEPTH = (NUM_BLOCKS + W - 1) / W;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int BW    = $clog2(NUM_BLOCKS + 1);
    localparam int CW    = (BW > REG_W) ? BW : REG_W;

    localparam logic [CW-1:0] NB_C     = CW'(NUM_BLOCKS);
    localparam logic [BW-1:0] NB_B     = BW'(NUM_BLOCKS);
    localparam logic [AW-1:0] LAST_ROW = AW'(DEPTH - 1);

    function automatic logic [AW-1:0] row_of(input logic [31:0] b);
        logic [31:0] t;
        t = b >> WB;
        return t[AW-1:0];
    endfunction

    function automatic logic [WB-1:0] off_of(input logic [31:0] b);
        return b[WB-1:0];
    endfunction

    function automatic logic [BW-1:0] clip(input logic [REG_W-1:0] v);
        logic [CW-1:0] e;
        e = CW'(v);
        if (e > NB_C) begin
            e = NB_C;
        end
        return e[BW-1:0];
    endfunction

    // configuration and state
    logic [REG_W-1:0] r_block_count, r_first_data, r_first_rsv;
    logic [BW-1:0]    r_fc, r_fdc;
    logic [CW-1:0]    r_sp;
    logic [ID_W-1:0]  r_id;
    logic [AW-1:0]    r_clr_row;

    // scanner
    logic             r_scan_act, r_chk_vld, r_chk_last;
    logic [AW-1:0]    r_rd_row, r_chk_row, r_lo_row, r_last_row, r_hit_row;
    logic [WB-1:0]    r_lo_off, r_last_off;
    logic [W-1:0]     r_hit_word;
    logic [BW-1:0]    r_hit_blk;

    logic [BW-1:0]    lim, fdb, frb, lo, hi, hi_m1;
    logic [W-1:0]     rdata, lo_mask, hi_mask, masked, id_mask;
    logic [WB-1:0]    pos, id_off;
    logic             any_hit, scan_hit, scan_miss;
    logic [31:0]      hit_x, hit_blk_x, fc_x, fdc_x;
    logic [AW-1:0]    id_row;
    logic             ram_we, ram_re;
    logic [AW-1:0]    ram_waddr, ram_raddr;
    logic [W-1:0]     ram_wdata;
    logic             upd_dec, upd_inc, upd_data;
    logic [CW-1:0]    upd_blk;

    assign lim = clip(r_block_count);
    assign fdb = clip(r_first_data);
    assign frb = clip(r_first_rsv);

    always_comb begin
        case (i_cmd.scan_sel)
            SC_PTR:  begin lo = r_sp[BW-1:0]; hi = lim; end
            SC_WRAP: begin lo = fdb;          hi = lim; end
            SC_RSV:  begin lo = frb;          hi = fdb; end
            default: begin lo = fdb;          hi = lim; end
        endcase
        hi_m1 = hi - 1'b1;
    end

    // check stage: word from the ram, clipped to [lo, hi)
    always_comb begin
        lo_mask = (r_chk_row == r_lo_row) ? ({W{1'b1}} << r_lo_off) : {W{1'b1}};
        hi_mask = (r_chk_row == r_last_row) ?
                  ({W{1'b1}} >> (WB'(W - 1) - r_last_off)) : {W{1'b1}};
        masked  = rdata & lo_mask & hi_mask;
        any_hit = |masked;
        pos     = '0;
        for (int i = W - 1; i >= 0; i--) begin
            if (masked[i]) begin
                pos = WB'(i);
            end
        end
        hit_x = (32'(r_chk_row) << WB) | 32'(pos);
    end

    assign scan_hit  = r_chk_vld & any_hit;
    assign scan_miss = r_chk_vld & r_chk_last & ~any_hit;

    assign id_off  = off_of(32'(r_id));
    assign id_row  = row_of(32'(r_id));
    assign id_mask = W'(1) << id_off;

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_hit_row;
        ram_wdata = r_hit_word;
        if (i_cmd.clear) begin
            ram_we    = 1'b1;
            ram_waddr = r_clr_row;
            ram_wdata = '0;
        end else if (i_cmd.take) begin
            ram_we    = 1'b1;
        end else if (i_cmd.id_take) begin
            ram_we    = 1'b1;
            ram_waddr = id_row;
            ram_wdata = rdata & ~id_mask;
        end else if (i_cmd.id_give) begin
            ram_we    = 1'b1;
            ram_waddr = id_row;
            ram_wdata = rdata | id_mask;
        end
    end

    assign ram_re    = r_scan_act | i_cmd.id_rd;
    assign ram_raddr = i_cmd.id_rd ? id_row : r_rd_row;

    bba_ram #(
        .WIDTH (W),
        .DEPTH (DEPTH)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (rdata)
    );

    // counter update: data region test uses the raw register
    assign upd_dec  = i_cmd.take | i_cmd.id_take;
    assign upd_inc  = i_cmd.id_give;
    assign upd_blk  = i_cmd.take ? CW'(r_hit_blk) : CW'(r_id);
    assign upd_data = upd_blk >= CW'(r_first_data);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block_count <= BLOCK_COUNT_RST;
            r_first_data  <= '0;
            r_first_rsv   <= '0;
            r_fc          <= '0;
            r_fdc         <= '0;
            r_sp          <= '0;
            r_clr_row     <= '0;
            r_scan_act    <= 1'b0;
            r_chk_vld     <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_BLOCK_COUNT: r_block_count <= i_cfg_data;
                    REG_FIRST_DATA:  r_first_data  <= i_cfg_data;
                    REG_FIRST_RSV:   r_first_rsv   <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.clear) begin
                r_clr_row <= r_clr_row + 1'b1;
            end
            if (upd_dec) begin
                if (r_fc != '0) r_fc <= r_fc - 1'b1;
                if (upd_data && r_fdc != '0) r_fdc <= r_fdc - 1'b1;
            end else if (upd_inc) begin
                if (r_fc != NB_B) r_fc <= r_fc + 1'b1;
                if (upd_data && r_fdc != NB_B) r_fdc <= r_fdc + 1'b1;
            end
            if (i_cmd.set_sp) begin
                r_sp <= CW'(r_id);
            end else if (i_cmd.take && i_cmd.take_sp) begin
                r_sp <= CW'(r_hit_blk) + 1'b1;
            end
            if (i_cmd.scan_start) begin
                r_scan_act <= 1'b1;
                r_chk_vld  <= 1'b0;
            end else begin
                r_chk_vld <= r_scan_act & ~scan_hit;
                if (scan_hit || (r_scan_act && r_rd_row == r_last_row)) begin
                    r_scan_act <= 1'b0;
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_id) begin
            r_id <= i_target_blk;
        end
        if (i_cmd.scan_start) begin
            r_rd_row   <= row_of(32'(lo));
            r_lo_row   <= row_of(32'(lo));
            r_lo_off   <= off_of(32'(lo));
            r_last_row <= row_of(32'(hi_m1));
            r_last_off <= off_of(32'(hi_m1));
        end else begin
            r_chk_row  <= r_rd_row;
            r_chk_last <= (r_rd_row == r_last_row);
            if (r_scan_act) begin
                r_rd_row <= r_rd_row + 1'b1;
            end
        end
        if (scan_hit) begin
            r_hit_row  <= r_chk_row;
            r_hit_word <= rdata & ~(W'(1) << pos);
            r_hit_blk  <= hit_x[BW-1:0];
        end
    end

    assign hit_blk_x = 32'(r_hit_blk);
    assign fc_x      = 32'(r_fc);
    assign fdc_x     = 32'(r_fdc);

    always_comb begin
        o_sts.clr_last        = (r_clr_row == LAST_ROW);
        o_sts.fc_zero         = (r_fc == '0);
        o_sts.sp_lt_lim       = (r_sp < CW'(lim));
        o_sts.fdb_lt_lim      = (fdb < lim);
        o_sts.frb_lt_fdb      = (frb < fdb);
        o_sts.id_bad          = (CW'(r_id) >= NB_C);
        o_sts.id_bit          = rdata[id_off];
        o_sts.scan_hit        = scan_hit;
        o_sts.scan_miss       = scan_miss;
        o_sts.hit_blk         = hit_blk_x[ID_W-1:0];
        o_sts.free_total      = fc_x[REG_W-1:0];
        o_sts.free_data_total = fdc_x[REG_W-1:0];
    end

endmodule

>>> design/bba_ctrl.sv
// controller of the bitmap block allocator: decodes commands, sequences the
// datapath and holds the response register; depends on bba_pkg
module bba_ctrl (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic [bba_pkg::CMD_W-1:0]  i_command,
    input  logic                       i_out_ready,
    output logic                       o_out_valid,
    output bba_pkg::t_rsp              o_rsp,
    output bba_pkg::t_dp_cmd           o_dp_cmd,
    input  bba_pkg::t_dp_sts           i_dp_sts
);
    import bba_pkg::*;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DECODE,
        S_SCAN1,
        S_SCAN2,
        S_SCANR,
        S_TAKE,
        S_IDCHK,
        S_DONE
    } t_state;

    t_state           r_state, n_state;
    logic [CMD_W-1:0] r_op, n_op;
    t_status          r_status, n_status;
    logic             r_granted, n_granted;
    logic             r_is_free, n_is_free;
    logic             r_out_valid, n_out_valid;
    t_rsp             r_rsp, n_rsp;

    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_status    = r_status;
        n_granted   = r_granted;
        n_is_free   = r_is_free;
        n_out_valid = (r_out_valid && i_out_ready) ? 1'b0 : r_out_valid;
        n_rsp       = r_rsp;
        o_dp_cmd    = '0;
        o_in_ready  = (r_state == S_IDLE);

        case (r_state)
            S_CLEAR: begin
                o_dp_cmd.clear = 1'b1;
                if (i_dp_sts.clr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                o_dp_cmd.load_id = i_in_valid;
                if (i_in_valid) begin
                    n_op      = i_command;
                    n_status  = ST_OK;
                    n_granted = 1'b0;
                    n_is_free = 1'b0;
                    n_state   = S_DECODE;
                end
            end
            S_DECODE: begin
                n_state = S_DONE;
                case (r_op)
                    CMD_ALLOC_DATA: begin
                        if (i_dp_sts.fc_zero) begin
                            n_status = ST_NOSPACE;
                        end else if (i_dp_sts.sp_lt_lim) begin
                            o_dp_cmd.scan_start = 1'b1;
                            o_dp_cmd.scan_sel   = SC_PTR;
                            n_state             = S_SCAN1;
                        end else if (i_dp_sts.fdb_lt_lim) begin
                            o_dp_cmd.scan_start = 1'b1;
                            o_dp_cmd.scan_sel   = SC_WRAP;
                            n_state             = S_SCAN2;
                        end else begin
                            n_status = ST_NOSPACE;
                        end
                    end
                    CMD_ALLOC_RSV: begin
                        if (i_dp_sts.frb_lt_fdb) begin
                            o_dp_cmd.scan_start = 1'b1;
                            o_dp_cmd.scan_sel   = SC_RSV;
                            n_state             = S_SCANR;
                        end else begin
                            n_status = ST_NOSPACE;
                        end
                    end
                    CMD_MARK_USED, CMD_MARK_FREE, CMD_QUERY: begin
                        if (i_dp_sts.id_bad) begin
                            n_status = ST_INVALID;
                        end else begin
                            o_dp_cmd.id_rd = 1'b1;
                            n_state        = S_IDCHK;
                        end
                    end
                    CMD_SET_PTR: begin
                        o_dp_cmd.set_sp = 1'b1;
                    end
                    default: begin
                        n_status = ST_INVALID;
                    end
                endcase
            end
            S_SCAN1: begin
                if (i_dp_sts.scan_hit) begin
                    n_state = S_TAKE;
                end else if (i_dp_sts.scan_miss) begin
                    if (i_dp_sts.fdb_lt_lim) begin
                        o_dp_cmd.scan_start = 1'b1;
                        o_dp_cmd.scan_sel   = SC_WRAP;
                        n_state             = S_SCAN2;
                    end else begin
                        n_status = ST_NOSPACE;
                        n_state  = S_DONE;
                    end
                end
            end
            S_SCAN2, S_SCANR: begin
                if (i_dp_sts.scan_hit) begin
                    n_state = S_TAKE;
                end else if (i_dp_sts.scan_miss) begin
                    n_status = ST_NOSPACE;
                    n_state  = S_DONE;
                end
            end
            S_TAKE: begin
                o_dp_cmd.take    = 1'b1;
                o_dp_cmd.take_sp = (r_op == CMD_ALLOC_DATA);
                n_granted        = 1'b1;
                n_state          = S_DONE;
            end
            S_IDCHK: begin
                n_state = S_DONE;
                case (r_op)
                    CMD_MARK_USED: begin
                        if (i_dp_sts.id_bit) o_dp_cmd.id_take = 1'b1;
                        else n_status = ST_INVALID;
                    end
                    CMD_MARK_FREE: begin
                        o_dp_cmd.id_give = ~i_dp_sts.id_bit;
                    end
                    default: begin
                        n_is_free = i_dp_sts.id_bit;
                    end
                endcase
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid           = 1'b1;
                    n_rsp.status          = r_status;
                    n_rsp.allocated_block = r_granted ? i_dp_sts.hit_blk : '0;
                    n_rsp.is_free         = r_is_free;
                    n_rsp.free_total      = i_dp_sts.free_total;
                    n_rsp.free_data_total = i_dp_sts.free_data_total;
                    n_state               = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_out_valid <= 1'b0;
            r_op        <= CMD_ALLOC_DATA;
            r_status    <= ST_OK;
            r_granted   <= 1'b0;
            r_is_free   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_op        <= n_op;
            r_status    <= n_status;
            r_granted   <= n_granted;
            r_is_free   <= n_is_free;
        end
        r_rsp <= n_rsp;
    end

    assign o_out_valid = r_out_valid;
    assign o_rsp       = r_rsp;

endmodule

>>> design/bitmap_block_allocator_unit.sv
// top level of the bitmap block allocator: next-fit free map over NUM_BLOCKS
// blocks; depends on bba_pkg, bba_ifs, bba_ram, bba_dp, bba_ctrl
//
// channel  | dir | transfer carries
// ---------+-----+-----------------------------------------------------------
// i_cmd    | in  | command, target_blk
// o_rsp    | out | status, allocated_block, is_free, free_total, free_data_total
// i_cfg    | in  | index (0 block count, 1 first data, 2 first reserved), data
//
// scanning: the free map lives in a ram of 64-bit words and the scanner checks
//   one word per cycle; a data allocation scans from the search pointer and, on a
//   miss, a second pass from the first data block; the response becomes valid in
//   the same cycle as the next command can be taken
// reset: after reset a clearing pass writes every map word to used, one word a
//   cycle; no command is taken meanwhile, configuration writes are taken at once
// stalls: the response sits in an output register; the next command is taken
//   while it waits, and work only pauses when a second response is ready
module bitmap_block_allocator_unit #(
    parameter int NUM_BLOCKS = 4096
) (
    input logic      i_clk,
    input logic      i_rst_n,
    bba_cmd_if.sink  i_cmd,
    bba_rsp_if.source o_rsp,
    bba_cfg_if.sink  i_cfg
);
    import bba_pkg::*;

    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;
    t_rsp    rsp;
    logic    in_ready;
    logic    out_valid;

    // config registers take a write in any cycle
    assign i_cfg.ready = 1'b1;
    assign i_cmd.ready = in_ready;

    // sequencer: decode, scan passes, take, response
    bba_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_cmd.valid),
        .o_in_ready  (in_ready),
        .i_command   (i_cmd.command),
        .i_out_ready (o_rsp.ready),
        .o_out_valid (out_valid),
        .o_rsp       (rsp),
        .o_dp_cmd    (dp_cmd),
        .i_dp_sts    (dp_sts)
    );

    // map ram, scanner, counters, pointer and config registers
    bba_dp #(
        .NUM_BLOCKS (NUM_BLOCKS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg.valid),
        .i_cfg_idx    (i_cfg.index),
        .i_cfg_data   (i_cfg.data),
        .i_target_blk (i_cmd.target_blk),
        .i_cmd        (dp_cmd),
        .o_sts        (dp_sts)
    );

    // response channel straight from the output register
    assign o_rsp.valid           = out_valid;
    assign o_rsp.status          = rsp.status;
    assign o_rsp.allocated_block = rsp.allocated_block;
    assign o_rsp.is_free         = rsp.is_free;
    assign o_rsp.free_total      = rsp.free_total;
    assign o_rsp.free_data_total = rsp.free_data_total;

endmodule
